/* rtl/ssid_pkg.sv */
// ssid_pkg: shared types and constants for the sorted set block.
// No dependencies; imported by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package ssid_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // request codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic compare;     // latch lt/eq flags against the key
      logic shift_up;    // insert: open a slot at the sorted place
      logic shift_down;  // delete: close the slot of the match
   } cell_ctrl_type;

endpackage

/* rtl/ssid_req_if.sv */
// ssid_req_if: request channel (valid/ready plus cmd and value).
// Depends on ssid_pkg for the field widths.
`timescale 1ns / 1ps

interface ssid_req_if
   import ssid_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

/* rtl/ssid_rsp_if.sv */
// ssid_rsp_if: result channel (valid/ready plus status fields and count).
// Depends on ssid_pkg for the field widths.
`timescale 1ns / 1ps

interface ssid_rsp_if
   import ssid_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               was_present;
   logic               rejected_full;
   logic [COUNT_W-1:0] count;

   modport source (output valid, output was_present, output rejected_full, output count,
                   input ready);
   modport sink   (input valid, input was_present, input rejected_full, input count,
                   output ready);
endinterface

/* rtl/ssid_cell.sv */
// ssid_cell: one slot of the sorted chain; holds one value and its compare flags.
// Depends on ssid_pkg; instantiated in a row by sorted_set_insert_delete_top.
`timescale 1ns / 1ps

module ssid_cell
   import ssid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctrl_type             ctrl,
   input  logic                      occupied,
   input  logic signed [VALUE_W-1:0] key,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic                      left_lt,
   input  logic signed [VALUE_W-1:0] right_entry,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      lt,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;

   // compare flags; only meaningful for occupied slots
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctrl.compare) begin
         lt_in = occupied && (entry_ff < key);
         eq_in = occupied && (entry_ff == key);
      end
   end

   // slots below the sorted place keep their word, the rest move
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_up && !lt_ff) begin
         entry_in = left_lt ? key : left_entry;
      end else if (ctrl.shift_down && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   // value storage, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

/* rtl/sorted_set_insert_delete_top.sv */
// sorted_set_insert_delete_top: sorted set of signed values held in a row of cells.
// Depends on ssid_pkg, ssid_req_if, ssid_rsp_if and ssid_cell.
`timescale 1ns / 1ps
//
//   channel | dir | handshake     | word
//   --------+-----+---------------+-------------------------------------
//   req     | in  | valid / ready | cmd (0 insert, 1 delete), value
//   rsp     | out | valid / ready | was_present, rejected_full, count
//
// Each request goes through three steps: accept, compare in every cell at once,
// then shift the row one slot up or down if the set changes. The next request
// is taken in the cycle after the update. The result sits in an output register;
// the update step waits only while that register still holds an untaken result.
// Reset clears the count and the control; stored values are not cleared.

module sorted_set_insert_delete_top
   import ssid_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   ssid_req_if.sink   req,
   ssid_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type                 state_ff, state_in;
   logic                      cmd_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      was_present_ff, rejected_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   cell_ctrl_type             ctrl;
   logic signed [VALUE_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]       lt_vec;
   logic [CAPACITY-1:0]       eq_vec;

   logic found, full, rsp_free, do_update, accept;

   assign accept    = req.valid && req.ready;
   assign found     = |eq_vec;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign do_update = (state_ff == ST_UPDATE) && rsp_free;

   // sequencer: next state, cell control, count
   always_comb begin
      state_in        = state_ff;
      req.ready       = 1'b0;
      ctrl.compare    = 1'b0;
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
      count_in        = count_ff;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
               if (cmd_ff == CMD_INSERT && !found && !full) begin
                  ctrl.shift_up = 1'b1;
                  count_in      = count_ff + 1'b1;
               end else if (cmd_ff == CMD_DELETE && found) begin
                  ctrl.shift_down = 1'b1;
                  count_in        = count_ff - 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // request word holding
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req.cmd;
         key_ff <= req.value;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_update)       rsp_valid_in = 1'b1;
      else if (rsp.ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (do_update) begin
         was_present_ff <= found;
         rejected_ff    <= (cmd_ff == CMD_INSERT) && !found && full;
         rsp_count_ff   <= COUNT_W'(count_in);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.was_present   = was_present_ff;
   assign rsp.rejected_full = rejected_ff;
   assign rsp.count         = rsp_count_ff;

   // row of cells; each sees its neighbors' words
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry, right_entry;
      logic                      left_lt;
      logic                      occupied;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_entry = key_ff;
         assign left_lt    = 1'b1;
      end else begin : g_mid
         assign left_entry = entry_vec[i-1];
         assign left_lt    = lt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_vec[i];
      end else begin : g_inner
         assign right_entry = entry_vec[i+1];
      end

      ssid_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .key         (key_ff),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .entry       (entry_vec[i]),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i])
      );
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 (state_ff == ST_UPDATE))
      else $error("request did not reach the update step");

   a_lt_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (((lt_vec >> 1) & ~lt_vec) == '0))
      else $error("less-than flags not a prefix: row out of order");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($countones(eq_vec) <= 1))
      else $error("value held in more than one cell");

   a_reject_only_full: assert property (@(posedge clock) disable iff (reset)
      (do_update && cmd_ff == CMD_INSERT && !found) |-> (full || ctrl.shift_up))
      else $error("insert neither placed nor rejected");

endmodule
